FILE: rtl/polyphonic_sample_voice_mixer_assert.svh
// assertion macros for the voice mixer
// used by polyphonic_sample_voice_mixer.sv, no other dependencies
`ifndef POLYPHONIC_SAMPLE_VOICE_MIXER_ASSERT_SVH
`define POLYPHONIC_SAMPLE_VOICE_MIXER_ASSERT_SVH

// same-cycle implication
`define PSVM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psvm assertion failed");

// next-cycle implication
`define PSVM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psvm assertion failed");

`endif

FILE: rtl/psvm_pkg.sv
// shared types and constants of the voice mixer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psvm_pkg;

   localparam int DEF_VOICE_COUNT  = 8;
   localparam int DEF_SAMPLE_DEPTH = 65536;
   localparam int DEF_FRAC_BITS    = 16;

   localparam logic [15:0] MASTER_GAIN_RESET = 16'd4096;
   localparam logic [19:0] GAIN_FLOOR_RESET  = 20'd7;

   // item kinds
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // start status codes
   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_STARTED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // register indexes
   localparam logic CSR_MASTER_GAIN = 1'b0;
   localparam logic CSR_GAIN_FLOOR  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_READ1,
      S_GET1,
      S_INTERP,
      S_MIX,
      S_ACCUM,
      S_FIN_LO,
      S_FIN_HI,
      S_FIN_SUM,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/polyphonic_sample_voice_mixer.sv
// polyphonic sample playback mixer: sample memory, voice record memory, tick sequencer
// depends on psvm_pkg and polyphonic_sample_voice_mixer_assert.svh
// a write or start item goes to S_RESP, then the output register holds its result
// a tick scans each voice, S_CHECK..S_ACCUM per playing voice, then S_FIN_LO..S_FIN_SUM
// one item at a time, two sample reads per voice; next item taken while a result waits
// reset: synchronous, clears all voices and the handshake state, restores master gain and floor
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_sample_voice_mixer #(
   parameter int VOICE_COUNT  = psvm_pkg::DEF_VOICE_COUNT,
   parameter int SAMPLE_DEPTH = psvm_pkg::DEF_SAMPLE_DEPTH,
   parameter int FRAC_BITS    = psvm_pkg::DEF_FRAC_BITS
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_action,
   input  wire  [15:0]        req_address,
   input  wire  signed [15:0] req_sample_value,
   input  wire  [16:0]        req_wave_length,
   input  wire  [18:0]        req_pitch_step,
   input  wire  [19:0]        req_start_gain,
   input  wire  [16:0]        req_decay,
   input  wire                req_stereo_mode,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   output logic               rsp_clipped,
   output logic [2:0]         rsp_voice_claimed,
   output logic [1:0]         rsp_start_status,
   output logic [7:0]         rsp_active_mask,
   input  wire                csr_write_en,
   input  wire                csr_index,
   input  wire  [19:0]        csr_data
);
   import psvm_pkg::*;

   // the user keeps sample depth a power of two, the block does not enforce it; addresses wrap
   localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
   localparam int VI_W    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int VC_W    = $clog2(VOICE_COUNT + 1);
   localparam int POS_W   = 18 + FRAC_BITS;
   localparam int CON_W   = 38;
   localparam int ACC_W   = CON_W + VC_W;
   localparam int LO_W    = 22;
   localparam int HI_W    = ACC_W - LO_W;
   localparam int TOT_W   = ACC_W + 18;
   localparam int SUM_LSB = 28;
   localparam int V_W     = TOT_W - SUM_LSB;
   localparam logic signed [TOT_W-1:0] ROUND_C = TOT_W'(1) << (SUM_LSB - 1);
   localparam logic signed [V_W-1:0]   VMAX    = V_W'(32767);
   localparam logic signed [V_W-1:0]   VMIN    = -V_W'(32768);

   // control
   state_type state_ff, state_in;
   logic [VC_W-1:0] vcnt_ff;
   logic [VI_W-1:0] vidx;
   logic [VOICE_COUNT-1:0] active_ff;
   logic accept;
   logic advance;
   logic end_chk;

   // configuration
   logic [15:0] master_gain_ff;
   logic [19:0] gain_floor_ff;

   // sample memory
   logic signed [15:0] smem [SAMPLE_DEPTH];
   logic signed [15:0] smem_rd_ff;
   logic [ADDR_W-1:0]  smem_raddr;
   logic               smem_we;

   // voice record memory, one entry per voice
   logic [POS_W-1:0] rpos_mem [VOICE_COUNT];
   logic [15:0]      rbase_mem [VOICE_COUNT];
   logic [16:0]      rlen_mem [VOICE_COUNT];
   logic [18:0]      rstep_mem [VOICE_COUNT];
   logic [19:0]      rgain_mem [VOICE_COUNT];
   logic [16:0]      rdecay_mem [VOICE_COUNT];
   logic             rster_mem [VOICE_COUNT];
   logic [POS_W-1:0] rpos_rd_ff;
   logic [15:0]      rbase_rd_ff;
   logic [16:0]      rlen_rd_ff;
   logic [18:0]      rstep_rd_ff;
   logic [19:0]      rgain_rd_ff;
   logic [16:0]      rdecay_rd_ff;
   logic             rster_rd_ff;
   logic             rec_we;
   logic [VI_W-1:0]  rec_waddr;
   logic [POS_W-1:0] wr_pos;
   logic [15:0]      wr_base;
   logic [16:0]      wr_len;
   logic [18:0]      wr_step;
   logic [19:0]      wr_gain;
   logic [16:0]      wr_decay;
   logic             wr_ster;

   // working copy of the voice being mixed
   logic [POS_W-1:0] w_pos_ff;
   logic [15:0]      w_base_ff;
   logic [16:0]      w_len_ff;
   logic [18:0]      w_step_ff;
   logic [19:0]      w_gain_ff;
   logic [16:0]      w_decay_ff;
   logic             w_ster_ff;
   logic [VI_W-1:0]  w_idx_ff;
   logic [ADDR_W-1:0] addr1_ff;

   // datapath
   logic signed [15:0] s0_ff, s1_ff;
   logic signed [16:0] interp_ff;
   logic signed [CON_W-1:0] cl_ff, cr_ff;
   logic [19:0] ngain_ff;
   logic signed [ACC_W-1:0] acc_l_ff, acc_r_ff;
   logic [LO_W+15:0] lol_ff, lor_ff;
   logic signed [HI_W+16:0] hil_ff, hir_ff;

   // pending result
   logic signed [15:0] pend_left_ff, pend_right_ff;
   logic pend_clip_ff;
   logic [2:0] pend_claimed_ff;
   logic [1:0] pend_status_ff;
   logic rsp_valid_ff;
   logic [7:0] mask_w;

   // start: lowest idle voice
   logic free_found;
   logic [VI_W-1:0] free_idx;

   // check stage
   logic [17:0] i0, len18, pair_hi, mono_i1, idx0, idx1;
   logic [ADDR_W-1:0] addr0, addr1;

   // mix stage
   logic signed [16:0] diff;
   logic signed [FRAC_BITS+17:0] iprod;
   logic signed [16:0] smp_l, smp_r;
   logic [36:0] gd;
   logic [20:0] ng_raw;
   logic [POS_W-1:0] pos_adv;

   // final stage
   logic [16:0] fin_l, fin_r;

   assign vidx   = vcnt_ff[VI_W-1:0];
   assign accept = req_valid && req_ready;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = VI_W'(i);
         end
      end
   end

   // end-of-voice checks on the record just read
   always_comb begin
      i0      = rpos_rd_ff[POS_W-1:FRAC_BITS];
      len18   = {1'b0, rlen_rd_ff};
      pair_hi = {i0[17:1], 1'b1};
      mono_i1 = i0 + 18'd1;
      end_chk = (i0 >= len18) || (rgain_rd_ff <= gain_floor_ff)
                || (rster_rd_ff && (pair_hi >= len18));
      if (rster_rd_ff) begin
         idx0 = {i0[17:1], 1'b0};
         idx1 = pair_hi;
      end else begin
         idx0 = i0;
         idx1 = (mono_i1 >= len18) ? i0 : mono_i1;
      end
      addr0 = ADDR_W'(rbase_rd_ff) + ADDR_W'(idx0);
      addr1 = ADDR_W'(rbase_rd_ff) + ADDR_W'(idx1);
   end

   // interpolation and gain
   always_comb begin
      diff   = {s1_ff[15], s1_ff} - {s0_ff[15], s0_ff};
      iprod  = diff * $signed({1'b0, w_pos_ff[FRAC_BITS-1:0]});
      smp_l  = w_ster_ff ? {s0_ff[15], s0_ff} : ({s0_ff[15], s0_ff} + interp_ff);
      smp_r  = w_ster_ff ? {s1_ff[15], s1_ff} : smp_l;
      gd     = w_gain_ff * w_decay_ff;
      ng_raw = gd[36:16];
      pos_adv = w_pos_ff + (w_ster_ff ? POS_W'({w_step_ff, 1'b0}) : POS_W'(w_step_ff));
   end

   // round, shift and saturate one channel; returns {clip, value}
   function automatic logic [16:0] finish_ch(input logic signed [HI_W+16:0] hp,
                                             input logic [LO_W+15:0] lp);
      logic signed [TOT_W-1:0] a;
      logic signed [TOT_W-1:0] b;
      logic signed [TOT_W-1:0] s;
      logic signed [V_W-1:0]   v;
      a = hp;
      a = a <<< LO_W;
      b = TOT_W'(lp);
      s = a + b + ROUND_C;
      v = s[TOT_W-1:SUM_LSB];
      if (v > VMAX) begin
         finish_ch = {1'b1, 16'sd32767};
      end else if (v < VMIN) begin
         finish_ch = {1'b1, 16'h8000};
      end else begin
         finish_ch = {1'b0, v[15:0]};
      end
   endfunction

   assign fin_l = finish_ch(hil_ff, lol_ff);
   assign fin_r = finish_ch(hir_ff, lor_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_action == ACT_TICK) ? S_SCAN : S_RESP;
            end
         end
         S_SCAN: begin
            if (vcnt_ff == VC_W'(VOICE_COUNT)) begin
               state_in = S_FIN_LO;
            end else if (active_ff[vidx]) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK:   state_in = end_chk ? S_SCAN : S_READ1;
         S_READ1:   state_in = S_GET1;
         S_GET1:    state_in = S_INTERP;
         S_INTERP:  state_in = S_MIX;
         S_MIX:     state_in = S_ACCUM;
         S_ACCUM:   state_in = S_SCAN;
         S_FIN_LO:  state_in = S_FIN_HI;
         S_FIN_HI:  state_in = S_FIN_SUM;
         S_FIN_SUM: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = 1'b0;
      smem_we    = 1'b0;
      smem_raddr = addr1_ff;
      rec_we     = 1'b0;
      rec_waddr  = w_idx_ff;
      advance    = 1'b0;
      wr_pos     = pos_adv;
      wr_base    = w_base_ff;
      wr_len     = w_len_ff;
      wr_step    = w_step_ff;
      wr_gain    = ngain_ff;
      wr_decay   = w_decay_ff;
      wr_ster    = w_ster_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            smem_we   = req_valid && (req_action == ACT_WRITE);
            rec_we    = req_valid && (req_action == ACT_START) && free_found;
            rec_waddr = free_idx;
            wr_pos    = '0;
            wr_base   = req_address;
            wr_len    = req_wave_length;
            wr_step   = req_pitch_step;
            wr_gain   = req_start_gain;
            wr_decay  = req_decay;
            wr_ster   = req_stereo_mode;
         end
         S_SCAN: begin
            advance = (vcnt_ff != VC_W'(VOICE_COUNT)) && !active_ff[vidx];
         end
         S_CHECK: begin
            smem_raddr = addr0;
            advance    = end_chk;
         end
         S_ACCUM: begin
            rec_we  = 1'b1;
            advance = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sample memory: one write and one read per cycle, read data registered
   always_ff @(posedge clock) begin
      if (smem_we) begin
         smem[ADDR_W'(req_address)] <= req_sample_value;
      end
      smem_rd_ff <= smem[smem_raddr];
   end

   // voice record memory
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rpos_mem[rec_waddr]   <= wr_pos;
         rbase_mem[rec_waddr]  <= wr_base;
         rlen_mem[rec_waddr]   <= wr_len;
         rstep_mem[rec_waddr]  <= wr_step;
         rgain_mem[rec_waddr]  <= wr_gain;
         rdecay_mem[rec_waddr] <= wr_decay;
         rster_mem[rec_waddr]  <= wr_ster;
      end
      rpos_rd_ff   <= rpos_mem[vidx];
      rbase_rd_ff  <= rbase_mem[vidx];
      rlen_rd_ff   <= rlen_mem[vidx];
      rstep_rd_ff  <= rstep_mem[vidx];
      rgain_rd_ff  <= rgain_mem[vidx];
      rdecay_rd_ff <= rdecay_mem[vidx];
      rster_rd_ff  <= rster_mem[vidx];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         master_gain_ff <= MASTER_GAIN_RESET;
         gain_floor_ff  <= GAIN_FLOOR_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_MASTER_GAIN) begin
            master_gain_ff <= csr_data[15:0];
         end else begin
            gain_floor_ff <= csr_data;
         end
      end
   end

   // voice scan counter and active bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff   <= '0;
         active_ff <= '0;
      end else begin
         if (accept && (req_action == ACT_TICK)) begin
            vcnt_ff <= '0;
         end else if (advance) begin
            vcnt_ff <= vcnt_ff + VC_W'(1);
         end
         if (rec_we && (state_ff == S_IDLE)) begin
            active_ff[free_idx] <= 1'b1;
         end
         // voice past its end or gain at or below the floor drops out silently
         if ((state_ff == S_CHECK) && end_chk) begin
            active_ff[vidx] <= 1'b0;
         end
      end
   end

   // tick datapath
   always_ff @(posedge clock) begin
      if (accept && (req_action == ACT_TICK)) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end
      case (state_ff)
         S_CHECK: begin
            w_pos_ff   <= rpos_rd_ff;
            w_base_ff  <= rbase_rd_ff;
            w_len_ff   <= rlen_rd_ff;
            w_step_ff  <= rstep_rd_ff;
            w_gain_ff  <= rgain_rd_ff;
            w_decay_ff <= rdecay_rd_ff;
            w_ster_ff  <= rster_rd_ff;
            w_idx_ff   <= vidx;
            addr1_ff   <= addr1;
         end
         S_READ1:  s0_ff <= smem_rd_ff;
         S_GET1:   s1_ff <= smem_rd_ff;
         S_INTERP: interp_ff <= 17'(iprod >>> FRAC_BITS);
         S_MIX: begin
            cl_ff    <= smp_l * $signed({1'b0, w_gain_ff});
            cr_ff    <= smp_r * $signed({1'b0, w_gain_ff});
            ngain_ff <= (ng_raw > 21'hFFFFF) ? 20'hFFFFF : ng_raw[19:0];
         end
         S_ACCUM: begin
            acc_l_ff <= acc_l_ff + ACC_W'(cl_ff);
            acc_r_ff <= acc_r_ff + ACC_W'(cr_ff);
         end
         // master gain product split in two halves, low half in S_FIN_LO, high half in S_FIN_HI
         S_FIN_LO: begin
            lol_ff <= acc_l_ff[LO_W-1:0] * master_gain_ff;
            lor_ff <= acc_r_ff[LO_W-1:0] * master_gain_ff;
         end
         S_FIN_HI: begin
            hil_ff <= $signed(acc_l_ff[ACC_W-1:LO_W]) * $signed({1'b0, master_gain_ff});
            hir_ff <= $signed(acc_r_ff[ACC_W-1:LO_W]) * $signed({1'b0, master_gain_ff});
         end
         default: begin
         end
      endcase
   end

   // pending result fields
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_left_ff    <= '0;
         pend_right_ff   <= '0;
         pend_clip_ff    <= 1'b0;
         pend_claimed_ff <= '0;
         pend_status_ff  <= STATUS_NONE;
         if (req_action == ACT_START) begin
            pend_status_ff  <= free_found ? STATUS_STARTED : STATUS_FULL;
            pend_claimed_ff <= free_found ? 3'(free_idx) : 3'd0;
         end
      end else if (state_ff == S_FIN_SUM) begin
         pend_left_ff  <= fin_l[15:0];
         pend_right_ff <= fin_r[15:0];
         pend_clip_ff  <= fin_l[16] || fin_r[16];
      end
   end

   // voices 0..7 shown in the mask
   for (genvar g = 0; g < 8; g++) begin : g_mask
      if (g < VOICE_COUNT) begin : g_on
         assign mask_w[g] = active_ff[g];
      end else begin : g_off
         assign mask_w[g] = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_left_out      <= pend_left_ff;
         rsp_right_out     <= pend_right_ff;
         rsp_clipped       <= pend_clip_ff;
         rsp_voice_claimed <= pend_claimed_ff;
         rsp_start_status  <= pend_status_ff;
         rsp_active_mask   <= mask_w;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "polyphonic_sample_voice_mixer_assert.svh"

   `PSVM_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   `PSVM_ASSERT_NOW(a_check_active, clock, reset, state_ff == S_CHECK, active_ff[vidx])
   `PSVM_ASSERT_NOW(a_start_silent, clock, reset,
      rsp_valid && (rsp_start_status != STATUS_NONE),
      (rsp_left_out == 16'sd0) && (rsp_right_out == 16'sd0) && !rsp_clipped)

endmodule

`default_nettype wire
